/* src/assert_macros.svh */
// Assertion helpers for the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is applied.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/slnorm_pkg.sv */
package slnorm_pkg;

	localparam int unsigned DIV_BITS = 63;

	localparam logic signed [63:0] IDX_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] IDX_MIN  = 64'sh8000_0000_0000_0000;
	localparam logic signed [63:0] STEP_MIN = 64'sh8000_0000_0000_0001;

	// One word travelling through the divider pipeline.
	typedef struct packed {
		logic              vld;
		logic [62:0]       rem;
		logic [62:0]       dvd;
		logic [62:0]       quo;
		logic [62:0]       mag;
		logic signed [63:0] start_idx;
		logic signed [63:0] stop_idx;
		logic signed [63:0] step;
		logic              err;
		logic              nz;
	} div_word_t;

endpackage

/* src/slnorm_front.sv */
module slnorm_front
	import slnorm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_vld,
	input  logic [62:0]        seq_length,
	input  logic signed [63:0] start_value,
	input  logic signed [63:0] stop_value,
	input  logic signed [63:0] step_value,
	input  logic               start_present,
	input  logic               stop_present,
	input  logic               step_present,
	output div_word_t          word_out
);

	function automatic logic signed [63:0] clamp_idx(input logic signed [63:0] idx,
			input logic signed [63:0] len, input logic neg);
		logic signed [63:0] t;
		begin
			t = idx;
			if (idx < 0) begin
				t = idx + len;
				if (t < 0) begin
					t = neg ? -64'sd1 : 64'sd0;
				end
			end else if (idx >= len) begin
				t = neg ? len - 64'sd1 : len;
			end
			return t;
		end
	endfunction

	// Stage 1: defaults and step clamp.
	logic               vld_s1, err_s1, neg_s1;
	logic signed [63:0] step_s1, start_s1, stop_s1, len_s1;
	logic signed [63:0] st_c;

	always_comb begin
		st_c = step_present ? step_value : 64'sd1;
		if (st_c == IDX_MIN) begin
			st_c = STEP_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		err_s1   <= step_present && (step_value == 64'sd0);
		neg_s1   <= st_c[63];
		step_s1  <= st_c;
		len_s1   <= {1'b0, seq_length};
		start_s1 <= start_present ? start_value : (st_c[63] ? IDX_MAX : 64'sd0);
		stop_s1  <= stop_present ? stop_value : (st_c[63] ? IDX_MIN : IDX_MAX);
	end

	// Stage 2: clamp both indices.
	logic               vld_s2, err_s2, neg_s2;
	logic signed [63:0] step_s2, start_s2, stop_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		err_s2   <= err_s1;
		neg_s2   <= neg_s1;
		step_s2  <= step_s1;
		start_s2 <= clamp_idx(start_s1, len_s1, neg_s1);
		stop_s2  <= clamp_idx(stop_s1, len_s1, neg_s1);
	end

	// Stage 3: span and step magnitude for the divider.
	logic signed [63:0] span_c, mag_c;
	logic               nz_c;

	always_comb begin
		if (neg_s2) begin
			nz_c   = stop_s2 < start_s2;
			span_c = start_s2 - stop_s2 - 64'sd1;
			mag_c  = -step_s2;
		end else begin
			nz_c   = start_s2 < stop_s2;
			span_c = stop_s2 - start_s2 - 64'sd1;
			mag_c  = step_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_out <= '0;
		end else begin
			word_out.vld       <= vld_s2;
			word_out.rem       <= '0;
			word_out.dvd       <= nz_c ? span_c[62:0] : 63'd0;
			word_out.quo       <= '0;
			word_out.mag       <= (mag_c[62:0] == 63'd0) ? 63'd1 : mag_c[62:0];
			word_out.start_idx <= start_s2;
			word_out.stop_idx  <= stop_s2;
			word_out.step      <= step_s2;
			word_out.err       <= err_s2;
			word_out.nz        <= nz_c;
		end
	end

endmodule

/* src/slnorm_div_stage.sv */
module slnorm_div_stage
	import slnorm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  div_word_t word_in,
	output div_word_t word_out
);

	// One restoring step: bring in the next dividend bit and try a subtract.
	logic [63:0] trial;
	logic [63:0] diff;
	logic        take;

	assign trial = {word_in.rem, word_in.dvd[62]};
	assign diff  = trial - {1'b0, word_in.mag};
	assign take  = trial >= {1'b0, word_in.mag};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_out <= '0;
		end else begin
			word_out.vld       <= word_in.vld;
			word_out.rem       <= take ? diff[62:0] : trial[62:0];
			word_out.dvd       <= {word_in.dvd[61:0], 1'b0};
			word_out.quo       <= {word_in.quo[61:0], take};
			word_out.mag       <= word_in.mag;
			word_out.start_idx <= word_in.start_idx;
			word_out.stop_idx  <= word_in.stop_idx;
			word_out.step      <= word_in.step;
			word_out.err       <= word_in.err;
			word_out.nz        <= word_in.nz;
		end
	end

endmodule

/* src/slice_index_normalize_core.sv */
// Each word passes through the front end, the divider stages and the output register.
// Throughput: one word per cycle; busy stays low, so start may be high every cycle.
// The 63 one-bit steps of the restoring divider set the depth of the pipeline.
// Reset: arst_n low clears all valid bits at once; words in flight are dropped.
// The receiver cannot stall: done marks a result for exactly one cycle.
`include "assert_macros.svh"

module slice_index_normalize_core
	import slnorm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [62:0]        seq_length,
	input  logic signed [63:0] start_value,
	input  logic signed [63:0] stop_value,
	input  logic signed [63:0] step_value,
	input  logic               start_present,
	input  logic               stop_present,
	input  logic               step_present,
	output logic               done,
	output logic signed [63:0] start_index,
	output logic signed [63:0] stop_index,
	output logic signed [63:0] step_out,
	output logic [62:0]        slice_length,
	output logic               error_flag
);

	// The pipeline never holds, so a new word is welcome in every cycle.
	assign busy = 1'b0;

	// The front end resolves defaults, clamps the indices and forms the
	// span and the step magnitude that the divider works on.
	div_word_t chain [DIV_BITS+1];

	slnorm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_vld        (start && !busy),
		.seq_length    (seq_length),
		.start_value   (start_value),
		.stop_value    (stop_value),
		.step_value    (step_value),
		.start_present (start_present),
		.stop_present  (stop_present),
		.step_present  (step_present),
		.word_out      (chain[0])
	);

	// Each divider stage produces one quotient bit, most significant first.
	for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
		slnorm_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.word_in  (chain[g]),
			.word_out (chain[g+1])
		);
	end

	div_word_t last;
	assign last = chain[DIV_BITS];

	// Output register: the element count is the quotient plus one when the
	// slice is not empty, and a zero step blanks every field but the flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		error_flag <= last.err;
		if (last.err) begin
			start_index  <= '0;
			stop_index   <= '0;
			step_out     <= '0;
			slice_length <= '0;
		end else begin
			start_index  <= last.start_idx;
			stop_index   <= last.stop_idx;
			step_out     <= last.step;
			slice_length <= last.nz ? last.quo + 63'd1 : 63'd0;
		end
	end

	`ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy must stay low")
	`ASSERT_CLK(a_err_blank, clk, arst_n, done && error_flag |-> (step_out == 64'sd0 && slice_length == 63'd0), "error word not blanked")
	`ASSERT_CLK(a_step_nonzero, clk, arst_n, done && !error_flag |-> step_out != 64'sd0, "zero step without error")
	`ASSERT_CLK(a_latency, clk, arst_n, done |-> $past(start, 67), "result without a matching start")

endmodule

/* dv/tb_slice_index_normalize_core.sv */
module tb_slice_index_normalize_core;
	import slnorm_pkg::*;

	// One slice request as presented on the input ports.
	typedef struct {
		logic [62:0]        seq_length;
		logic signed [63:0] start_value;
		logic signed [63:0] stop_value;
		logic signed [63:0] step_value;
		logic               start_present;
		logic               stop_present;
		logic               step_present;
	} slice_req_t;

	// One normalized slice as it should appear on the result ports.
	typedef struct {
		logic signed [63:0] start_index;
		logic signed [63:0] stop_index;
		logic signed [63:0] step_out;
		logic [62:0]        slice_length;
		logic               error_flag;
	} slice_res_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 80;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [62:0]        seq_length;
	logic signed [63:0] start_value;
	logic signed [63:0] stop_value;
	logic signed [63:0] step_value;
	logic               start_present;
	logic               stop_present;
	logic               step_present;
	logic               done;
	logic signed [63:0] start_index;
	logic signed [63:0] stop_index;
	logic signed [63:0] step_out;
	logic [62:0]        slice_length;
	logic               error_flag;

	slice_req_t pending_reqs[$];
	slice_res_t expected_slices[$];
	int         mismatch_count;
	int         idle_cycles;
	int         gap_left;
	bit         quiet_phase;

	slice_index_normalize_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.seq_length(seq_length), .start_value(start_value),
		.stop_value(stop_value), .step_value(step_value),
		.start_present(start_present), .stop_present(stop_present),
		.step_present(step_present), .done(done),
		.start_index(start_index), .stop_index(stop_index),
		.step_out(step_out), .slice_length(slice_length),
		.error_flag(error_flag)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Pull one index into range; the negative step case allows -1 and len-1.
	function automatic logic signed [63:0] clamp_slice_index(logic signed [63:0] idx,
			logic signed [63:0] len, bit neg);
		logic signed [63:0] r;
		r = idx;
		if (r < 0) begin
			r = r + len;
			if (r < 0)
				r = neg ? -64'sd1 : 64'sd0;
		end else if (r >= len) begin
			r = neg ? len - 64'sd1 : len;
		end
		return r;
	endfunction

	// Work out the normalized slice for one request.
	function automatic slice_res_t normalize_slice(slice_req_t q);
		slice_res_t         r;
		logic signed [63:0] len, stp, b, e;
		logic [63:0]        span, mag;
		bit                 neg;
		r = '{default: '0};
		len = {1'b0, q.seq_length};
		if (q.step_present) begin
			stp = q.step_value;
			if (stp == 0) begin
				r.error_flag = 1'b1;
				return r;
			end
			if (stp == IDX_MIN)
				stp = STEP_MIN;
		end else begin
			stp = 64'sd1;
		end
		neg = stp < 0;
		b = q.start_present ? q.start_value : (neg ? IDX_MAX : 64'sd0);
		e = q.stop_present ? q.stop_value : (neg ? IDX_MIN : IDX_MAX);
		b = clamp_slice_index(b, len, neg);
		e = clamp_slice_index(e, len, neg);
		if (neg && e < b) begin
			span = b - e - 64'd1;
			mag = -stp;
			r.slice_length = 63'(span / mag + 64'd1);
		end else if (!neg && b < e) begin
			span = e - b - 64'd1;
			r.slice_length = 63'(span / stp + 64'd1);
		end
		r.start_index = b;
		r.stop_index = e;
		r.step_out = stp;
		return r;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Lengths and indices are mostly small so that clamping and counting matter,
	// with full-width values mixed in to exercise every bit.
	function automatic logic signed [63:0] pick_index(logic [62:0] len);
		case ($urandom_range(0, 5))
			0: return rand64();
			1: return $signed(64'($urandom_range(0, 40))) - 64'sd20;
			2: return {1'b0, len} - 64'($urandom_range(0, 3));
			3: return -$signed({1'b0, len}) + $signed(64'($urandom_range(0, 3))) - 64'sd1;
			4: return $urandom_range(0, 1) ? IDX_MAX : IDX_MIN;
			default: return $signed(64'($urandom_range(0, 200)));
		endcase
	endfunction

	function automatic slice_req_t random_req();
		slice_req_t q;
		case ($urandom_range(0, 3))
			0: q.seq_length = 63'(rand64());
			1: q.seq_length = 63'h7FFF_FFFF_FFFF_FFFF - 63'($urandom_range(0, 3));
			default: q.seq_length = 63'($urandom_range(0, 100));
		endcase
		q.start_value = pick_index(q.seq_length);
		q.stop_value = pick_index(q.seq_length);
		case ($urandom_range(0, 7))
			0: q.step_value = rand64();
			1: q.step_value = 64'sd0;
			2: q.step_value = $urandom_range(0, 1) ? IDX_MIN : STEP_MIN;
			3: q.step_value = IDX_MAX - 64'($urandom_range(0, 1));
			default: q.step_value = $signed(64'($urandom_range(0, 14))) - 64'sd7;
		endcase
		q.start_present = $urandom_range(0, 3) != 0;
		q.stop_present = $urandom_range(0, 3) != 0;
		q.step_present = $urandom_range(0, 4) != 0;
		return q;
	endfunction

	function automatic slice_req_t make_req(logic [62:0] len, logic signed [63:0] b,
			logic signed [63:0] e, logic signed [63:0] s, bit bp, bit ep, bit sp);
		slice_req_t q;
		q.seq_length = len;
		q.start_value = b;
		q.stop_value = e;
		q.step_value = s;
		q.start_present = bp;
		q.stop_present = ep;
		q.step_present = sp;
		return q;
	endfunction

	// Prints one line per mismatching field and counts it.
	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h, expected %h", field, got, want);
		mismatch_count++;
	endtask

	// Driver: presents the oldest pending word, with random gaps except in the
	// quiet tail of the run. busy is honored even though the block is expected
	// to keep it low.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			gap_left <= 0;
		end else begin
			if (start && !busy) begin
				expected_slices.push_back(normalize_slice(pending_reqs.pop_front()));
			end
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					start <= 1'b0;
				end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
					gap_left <= $urandom_range(0, 2);
					start <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					start <= 1'b1;
					seq_length <= pending_reqs[0].seq_length;
					start_value <= pending_reqs[0].start_value;
					stop_value <= pending_reqs[0].stop_value;
					step_value <= pending_reqs[0].step_value;
					start_present <= pending_reqs[0].start_present;
					stop_present <= pending_reqs[0].stop_present;
					step_present <= pending_reqs[0].step_present;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every done word is checked field by field against the oldest
	// expectation. The watchdog counts cycles in which nothing is accepted and no result arrives.
	always @(posedge clk) begin
		slice_res_t want;
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (expected_slices.size() == 0) begin
					report_mismatch("unexpected done", 64'd1, 64'd0);
				end else begin
					want = expected_slices.pop_front();
					if (error_flag !== want.error_flag)
						report_mismatch("error_flag", 64'(error_flag), 64'(want.error_flag));
					if (start_index !== want.start_index)
						report_mismatch("start_index", start_index, want.start_index);
					if (stop_index !== want.stop_index)
						report_mismatch("stop_index", stop_index, want.stop_index);
					if (step_out !== want.step_out)
						report_mismatch("step_out", step_out, want.step_out);
					if (slice_length !== want.slice_length)
						report_mismatch("slice_length", 64'(slice_length),
							64'(want.slice_length));
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("slice_index_normalize_core verification failed");
				$finish;
			end
		end
	end

	initial begin
		int n;
		arst_n = 1'b0;
		start = 1'b0;
		seq_length = '0;
		start_value = '0;
		stop_value = '0;
		step_value = '0;
		start_present = 1'b0;
		stop_present = 1'b0;
		step_present = 1'b0;
		mismatch_count = 0;
		idle_cycles = 0;
		quiet_phase = 1'b0;

		// Directed words: defaults, zero step, most negative step, extremes.
		pending_reqs.push_back(make_req(63'd10, 0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(63'd10, 0, 0, 0, 0, 0, 1));
		pending_reqs.push_back(make_req(63'd10, 5, 7, -1, 0, 0, 1));
		pending_reqs.push_back(make_req(63'd10, 0, 0, IDX_MIN, 0, 0, 1));
		pending_reqs.push_back(make_req(63'd10, 9, 0, STEP_MIN, 1, 1, 1));
		pending_reqs.push_back(make_req(63'd10, -3, -1, 1, 1, 1, 1));
		pending_reqs.push_back(make_req(63'd10, -100, 100, 3, 1, 1, 1));
		pending_reqs.push_back(make_req(63'd10, 100, -100, -3, 1, 1, 1));
		pending_reqs.push_back(make_req(63'd0, 0, 0, -1, 1, 1, 1));
		pending_reqs.push_back(make_req(63'd0, 0, 0, 1, 0, 0, 0));
		pending_reqs.push_back(make_req('1, IDX_MIN, IDX_MAX, 1, 1, 1, 1));
		pending_reqs.push_back(make_req('1, IDX_MAX, IDX_MIN, -1, 1, 1, 1));
		pending_reqs.push_back(make_req('1, 0, 0, IDX_MAX, 0, 0, 1));
		pending_reqs.push_back(make_req('1, 0, 0, STEP_MIN, 0, 0, 1));
		pending_reqs.push_back(make_req('1, -1, -1, 2, 1, 1, 1));
		pending_reqs.push_back(make_req(63'd7, 7, 7, 1, 1, 1, 1));
		pending_reqs.push_back(make_req(63'd7, 6, -8, -2, 1, 1, 1));
		pending_reqs.push_back(make_req(63'd7, '1, '1, '1, 1, 1, 1));
		for (n = 0; n < 700; n++)
			pending_reqs.push_back(random_req());

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Quiet tail: the last stretch runs with no gaps.
		wait (pending_reqs.size() < 80);
		quiet_phase = 1'b1;
		wait (pending_reqs.size() == 0 && expected_slices.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_slices.size() == 0)
			$display("slice_index_normalize_core verification clean");
		else
			$display("slice_index_normalize_core verification failed");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+src
src/slnorm_pkg.sv
src/slnorm_front.sv
src/slnorm_div_stage.sv
src/slice_index_normalize_core.sv
dv/tb_slice_index_normalize_core.sv
